// ===== src/smat_pkg.sv =====
// Package for the shadow memory access tracker.
// Holds field widths, default parameters, payload structs, controller state
// and the command/status structs between controller and datapath.
package smat_pkg;

  localparam int SHADOW_AW_DEF        = 12;
  localparam int THREAD_SLOTS_DEF     = 32;
  localparam int EVENT_BITS_DEF       = 32;
  localparam int MAX_ACCESS_BYTES_DEF = 16;

  localparam int ACTION_W = 2;
  localparam int ADDR_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int TID_W    = 5;
  localparam int EVENT_W  = 32;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   address;
    logic [COUNT_W-1:0]  byte_count;
    logic [TID_W-1:0]    thread_id;
    logic [EVENT_W-1:0]  event_id;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0]   writer_thread;
    logic [EVENT_W-1:0] writer_event;
    logic               thread_has_read;
    logic               range_error;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_WRITE,
    ST_READ,
    ST_DRAIN,
    ST_QUERY
  } ctl_state_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic wr_step;
    logic rd_issue;
    logic finish;
    logic finish_query;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                err;
    logic                empty;
    logic                cnt_last;
    logic                clear_last;
  } status_t;

endpackage

// ===== src/shadow_memory_access_tracker_top.sv =====
// Shadow memory access tracker, top level. Depends on smat_pkg, smat_ctrl
// and smat_datapath.
//
// A request transfers on req at a rising edge where start is high and busy is
// low. Action write records thread and event over byte_count bytes, at most
// MAX_ACCESS_BYTES, from address and clears their reader bitmaps; action read
// sets the thread's bit over the range; action query reads one byte. Each
// request produces one result on rsp, shown for exactly one cycle with done
// high; the receiver cannot stall it.
// After the accepting edge a request is decoded; then a write stores, or a
// read updates, one shadow entry per cycle on the memory write port (a read
// then drains), a query reads its entry, and a range error, an empty range
// or an unused action finish at decode. busy is low again in the done cycle,
// so the next request may transfer there; none is taken while it is high.
// After reset the block sweeps all 2^SHADOW_AW shadow entries to zero, one
// per cycle, with busy high.
module shadow_memory_access_tracker_top #(
  parameter int SHADOW_AW        = smat_pkg::SHADOW_AW_DEF,
  parameter int THREAD_SLOTS     = smat_pkg::THREAD_SLOTS_DEF,
  parameter int EVENT_BITS       = smat_pkg::EVENT_BITS_DEF,
  parameter int MAX_ACCESS_BYTES = smat_pkg::MAX_ACCESS_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  smat_pkg::req_t  req,
  output logic            done,
  output smat_pkg::rsp_t  rsp
);

  smat_pkg::cmd_t    cmd;
  smat_pkg::status_t status;

  smat_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  smat_datapath #(
    .SHADOW_AW        (SHADOW_AW),
    .THREAD_SLOTS     (THREAD_SLOTS),
    .EVENT_BITS       (EVENT_BITS),
    .MAX_ACCESS_BYTES (MAX_ACCESS_BYTES)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .done   (done),
    .rsp    (rsp)
  );

endmodule

// ===== src/smat_ctrl.sv =====
// Controller state machine of the shadow memory access tracker.
// Sequences the clearing pass, write and read sweeps and queries.
// Depends on smat_pkg.
module smat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  smat_pkg::status_t  status,
  output smat_pkg::cmd_t     cmd
);

  smat_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smat_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      smat_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = smat_pkg::ST_IDLE;
      end
      smat_pkg::ST_IDLE: begin
        if (start) state_next = smat_pkg::ST_DECODE;
      end
      smat_pkg::ST_DECODE: begin
        case (status.action)
          smat_pkg::ACT_WRITE: begin
            state_next = (status.err || status.empty) ? smat_pkg::ST_IDLE : smat_pkg::ST_WRITE;
          end
          smat_pkg::ACT_READ: begin
            state_next = (status.err || status.empty) ? smat_pkg::ST_IDLE : smat_pkg::ST_READ;
          end
          smat_pkg::ACT_QUERY: begin
            state_next = status.err ? smat_pkg::ST_IDLE : smat_pkg::ST_QUERY;
          end
          default: state_next = smat_pkg::ST_IDLE;
        endcase
      end
      smat_pkg::ST_WRITE: begin
        if (status.cnt_last) state_next = smat_pkg::ST_IDLE;
      end
      smat_pkg::ST_READ: begin
        if (status.cnt_last) state_next = smat_pkg::ST_DRAIN;
      end
      smat_pkg::ST_DRAIN: state_next = smat_pkg::ST_IDLE;
      smat_pkg::ST_QUERY: state_next = smat_pkg::ST_IDLE;
      default: state_next = smat_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      smat_pkg::ST_CLEAR: cmd.clear = 1'b1;
      smat_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      smat_pkg::ST_DECODE: begin
        case (status.action)
          smat_pkg::ACT_WRITE: cmd.finish = status.err || status.empty;
          smat_pkg::ACT_READ:  cmd.finish = status.err || status.empty;
          smat_pkg::ACT_QUERY: cmd.finish = status.err;
          default:             cmd.finish = 1'b1;
        endcase
      end
      smat_pkg::ST_WRITE: begin
        cmd.wr_step = 1'b1;
        cmd.finish  = status.cnt_last;
      end
      smat_pkg::ST_READ: cmd.rd_issue = 1'b1;
      smat_pkg::ST_DRAIN: cmd.finish = 1'b1;
      smat_pkg::ST_QUERY: begin
        cmd.finish       = 1'b1;
        cmd.finish_query = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.capture, cmd.wr_step, cmd.rd_issue}))
    else $error("more than one datapath command at once");

  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == smat_pkg::ST_IDLE)
    else $error("finish not followed by idle");

  a_reset_busy: assert property (@(posedge clk)
    $past(rst) |-> busy)
    else $error("not busy while clearing after reset");
`endif

endmodule

// ===== src/smat_datapath.sv =====
// Datapath of the shadow memory access tracker: request registers, sweep
// counters, the three shadow memories and the result register.
// Depends on smat_pkg.
module smat_datapath #(
  parameter int SHADOW_AW        = smat_pkg::SHADOW_AW_DEF,
  parameter int THREAD_SLOTS     = smat_pkg::THREAD_SLOTS_DEF,
  parameter int EVENT_BITS       = smat_pkg::EVENT_BITS_DEF,
  parameter int MAX_ACCESS_BYTES = smat_pkg::MAX_ACCESS_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  smat_pkg::req_t     req,
  input  smat_pkg::cmd_t     cmd,
  output smat_pkg::status_t  status,
  output logic               done,
  output smat_pkg::rsp_t     rsp
);

  localparam int DEPTH = 2 ** SHADOW_AW;
  localparam int SUM_W = smat_pkg::ADDR_W + 1;
  localparam int CMP_W = 8;

  logic [smat_pkg::TID_W-1:0]   mem_writer [DEPTH];
  logic [EVENT_BITS-1:0]        mem_event  [DEPTH];
  logic [THREAD_SLOTS-1:0]      mem_bitmap [DEPTH];

  logic [smat_pkg::TID_W-1:0]   rd_writer;
  logic [EVENT_BITS-1:0]        rd_event;
  logic [THREAD_SLOTS-1:0]      rd_bitmap;

  logic [smat_pkg::ACTION_W-1:0] act;
  logic                          err_flag;
  logic [smat_pkg::COUNT_W-1:0]  cnt;
  logic [SHADOW_AW-1:0]          idx;
  logic [SHADOW_AW-1:0]          rmw_addr;
  logic                          rmw_valid;
  logic [smat_pkg::TID_W-1:0]    tid;
  logic [EVENT_BITS-1:0]         ev;
  logic [THREAD_SLOTS-1:0]       tmask;

  logic [smat_pkg::COUNT_W-1:0]            cnt_sat;
  logic [SUM_W-1:0]                        end_sum;
  logic                                    acc_over;
  logic                                    query_over;
  logic                                    err_in;
  logic                                    tid_valid;
  logic [THREAD_SLOTS-1:0]                 tmask_in;
  logic [EVENT_BITS+smat_pkg::EVENT_W-1:0] ev_in_wide;
  logic [EVENT_BITS+smat_pkg::EVENT_W-1:0] ev_out_wide;

  logic                          wr_we;
  logic [smat_pkg::TID_W-1:0]    wr_writer;
  logic [EVENT_BITS-1:0]         wr_event;
  logic                          bm_we;
  logic [SHADOW_AW-1:0]          bm_addr;
  logic [THREAD_SLOTS-1:0]       bm_data;

  always_comb begin
    cnt_sat = ({{(CMP_W-smat_pkg::COUNT_W){1'b0}}, req.byte_count} > CMP_W'(MAX_ACCESS_BYTES))
            ? smat_pkg::COUNT_W'(MAX_ACCESS_BYTES) : req.byte_count;
    end_sum    = {1'b0, req.address} + SUM_W'(cnt_sat);
    acc_over   = (cnt_sat != '0) && (end_sum > SUM_W'(DEPTH));
    query_over = {1'b0, req.address} >= SUM_W'(DEPTH);
    case (req.action)
      smat_pkg::ACT_WRITE: err_in = acc_over;
      smat_pkg::ACT_READ:  err_in = acc_over;
      smat_pkg::ACT_QUERY: err_in = query_over;
      default:             err_in = 1'b0;
    endcase
    tid_valid  = 32'(req.thread_id) < 32'(THREAD_SLOTS);
    tmask_in   = tid_valid ? (THREAD_SLOTS'(1) << req.thread_id) : '0;
    ev_in_wide = {{EVENT_BITS{1'b0}}, req.event_id};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      rmw_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      rmw_valid <= cmd.rd_issue;
      done      <= cmd.finish;
      if (cmd.capture) begin
        idx <= req.address[SHADOW_AW-1:0];
      end else if (cmd.clear || cmd.wr_step || cmd.rd_issue) begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act      <= req.action;
      err_flag <= err_in;
      cnt      <= cnt_sat;
      tid      <= req.thread_id;
      ev       <= ev_in_wide[EVENT_BITS-1:0];
      tmask    <= tmask_in;
    end else if (cmd.wr_step || cmd.rd_issue) begin
      cnt <= cnt - 1'b1;
    end
    if (cmd.rd_issue) begin
      rmw_addr <= idx;
    end
  end

  always_comb begin
    wr_we     = cmd.clear || cmd.wr_step;
    wr_writer = cmd.clear ? '0 : tid;
    wr_event  = cmd.clear ? '0 : ev;
    bm_we     = cmd.clear || cmd.wr_step || rmw_valid;
    bm_addr   = rmw_valid ? rmw_addr : idx;
    bm_data   = rmw_valid ? (rd_bitmap | tmask) : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_we) begin
      mem_writer[idx] <= wr_writer;
    end
    rd_writer <= mem_writer[idx];
  end

  always_ff @(posedge clk) begin
    if (wr_we) begin
      mem_event[idx] <= wr_event;
    end
    rd_event <= mem_event[idx];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      mem_bitmap[bm_addr] <= bm_data;
    end
    rd_bitmap <= mem_bitmap[idx];
  end

  assign ev_out_wide = {{smat_pkg::EVENT_W{1'b0}}, rd_event};

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp.writer_thread   <= cmd.finish_query ? rd_writer : '0;
      rsp.writer_event    <= cmd.finish_query ? ev_out_wide[smat_pkg::EVENT_W-1:0] : '0;
      rsp.thread_has_read <= cmd.finish_query && ((rd_bitmap & tmask) != '0);
      rsp.range_error     <= err_flag;
    end
  end

  always_comb begin
    status.action     = act;
    status.err        = err_flag;
    status.empty      = cnt == '0;
    status.cnt_last   = cnt == smat_pkg::COUNT_W'(1);
    status.clear_last = idx == {SHADOW_AW{1'b1}};
  end

`ifndef ASSERT_OFF
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (rmw_valid && cmd.rd_issue) |-> idx == rmw_addr + 1'b1)
    else $error("read sweep out of order with pending update");

  a_done_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.finish))
    else $error("result strobe without finish");

  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(cmd.finish_query)) |->
      (rsp.writer_thread == '0 && rsp.writer_event == '0 && !rsp.thread_has_read))
    else $error("non-query result carries query fields");
`endif

endmodule

// ===== tb/shadow_memory_access_tracker_top_tb.sv =====
// Self-checking testbench for shadow_memory_access_tracker_top.
// Depends on smat_pkg. Drives directed and random write, read and query
// transfers and compares every result against a local shadow store model.
module shadow_memory_access_tracker_top_tb;

  localparam int SHADOW_DEPTH = 1 << smat_pkg::SHADOW_AW_DEF;
  localparam logic [smat_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  smat_pkg::req_t req = '0;
  logic busy;
  logic done;
  smat_pkg::rsp_t rsp;

  logic [smat_pkg::TID_W-1:0]            writer_shadow [SHADOW_DEPTH];
  logic [smat_pkg::EVENT_W-1:0]          event_shadow [SHADOW_DEPTH];
  logic [smat_pkg::THREAD_SLOTS_DEF-1:0] reader_shadow [SHADOW_DEPTH];

  smat_pkg::rsp_t expected_rsp [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned write_count = 0;
  int unsigned read_count = 0;
  int unsigned query_count = 0;
  int unsigned error_count = 0;
  int unsigned hit_count = 0;
  bit gaps_on = 1'b1;

  shadow_memory_access_tracker_top u_top (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_rsp.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic smat_pkg::rsp_t predict_access(input smat_pkg::req_t r);
    smat_pkg::rsp_t res;
    logic [63:0] last_byte;
    int unsigned n;
    int unsigned idx;
    logic [smat_pkg::THREAD_SLOTS_DEF-1:0] tbit;
    res = '0;
    n = (r.byte_count > smat_pkg::MAX_ACCESS_BYTES_DEF) ? smat_pkg::MAX_ACCESS_BYTES_DEF
                                                         : r.byte_count;
    tbit = '0;
    if (r.thread_id < smat_pkg::THREAD_SLOTS_DEF) tbit[r.thread_id] = 1'b1;
    case (r.action)
      smat_pkg::ACT_WRITE, smat_pkg::ACT_READ: begin
        last_byte = {32'b0, r.address} + n - 1;
        if (n != 0 && last_byte >= SHADOW_DEPTH) begin
          res.range_error = 1'b1;
        end else begin
          for (int i = 0; i < n; i++) begin
            idx = r.address + i;
            if (r.action == smat_pkg::ACT_WRITE) begin
              writer_shadow[idx] = r.thread_id;
              event_shadow[idx]  = r.event_id;
              reader_shadow[idx] = '0;
            end else begin
              reader_shadow[idx] = reader_shadow[idx] | tbit;
            end
          end
        end
      end
      smat_pkg::ACT_QUERY: begin
        if (r.address >= SHADOW_DEPTH) begin
          res.range_error = 1'b1;
        end else begin
          idx = r.address;
          res.writer_thread   = writer_shadow[idx];
          res.writer_event    = event_shadow[idx];
          res.thread_has_read = |(reader_shadow[idx] & tbit);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, name, exp, act);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    smat_pkg::rsp_t exp;
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, rsp);
        fail_count++;
      end else begin
        exp = expected_rsp.pop_front();
        check_field("writer_thread", 64'(exp.writer_thread), 64'(rsp.writer_thread));
        check_field("writer_event", 64'(exp.writer_event), 64'(rsp.writer_event));
        check_field("thread_has_read", 64'(exp.thread_has_read), 64'(rsp.thread_has_read));
        check_field("range_error", 64'(exp.range_error), 64'(rsp.range_error));
      end
    end
  end

  task automatic send_request(input smat_pkg::req_t item);
    int unsigned gap;
    smat_pkg::rsp_t pred;
    if (gaps_on && $urandom_range(0, 99) < 17) begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    pred = predict_access(item);
    expected_rsp.push_back(pred);
    case (item.action)
      smat_pkg::ACT_WRITE: write_count++;
      smat_pkg::ACT_READ:  read_count++;
      smat_pkg::ACT_QUERY: query_count++;
      default: ;
    endcase
    if (pred.range_error) error_count++;
    if (pred.thread_has_read) hit_count++;
  endtask

  task automatic send_fields(input logic [smat_pkg::ACTION_W-1:0] action,
                             input logic [smat_pkg::ADDR_W-1:0] addr,
                             input logic [smat_pkg::COUNT_W-1:0] count,
                             input logic [smat_pkg::TID_W-1:0] tid,
                             input logic [smat_pkg::EVENT_W-1:0] eid);
    smat_pkg::req_t item;
    item.action     = action;
    item.address    = addr;
    item.byte_count = count;
    item.thread_id  = tid;
    item.event_id   = eid;
    send_request(item);
  endtask

  task automatic test_reset_state();
    send_fields(smat_pkg::ACT_QUERY, 32'd0, 5'd0, 5'd0, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, SHADOW_DEPTH - 1, 5'd1, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_write_read_query();
    send_fields(smat_pkg::ACT_WRITE, 32'd0, 5'd1, 5'd31, 32'hFFFF_FFFF);
    send_fields(smat_pkg::ACT_QUERY, 32'd0, 5'd0, 5'd31, 32'd0);
    send_fields(smat_pkg::ACT_READ, 32'd0, 5'd16, 5'd31, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, 32'd0, 5'd0, 5'd31, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, 32'd15, 5'd0, 5'd0, 32'd0);
    send_fields(smat_pkg::ACT_WRITE, 32'd0, 5'd4, 5'd0, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, 32'd0, 5'd0, 5'd31, 32'd0);
  endtask

  task automatic test_range_edges();
    send_fields(smat_pkg::ACT_WRITE, SHADOW_DEPTH - 1, 5'd1, 5'd7, 32'h1234_5678);
    send_fields(smat_pkg::ACT_WRITE, SHADOW_DEPTH - 1, 5'd2, 5'd8, 32'h8765_4321);
    send_fields(smat_pkg::ACT_READ, SHADOW_DEPTH - 16, 5'd16, 5'd3, 32'd0);
    send_fields(smat_pkg::ACT_READ, SHADOW_DEPTH - 15, 5'd16, 5'd4, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, SHADOW_DEPTH - 1, 5'd0, 5'd3, 32'd0);
    send_fields(smat_pkg::ACT_WRITE, 32'hFFFF_FFFF, 5'd16, 5'd1, 32'd1);
    send_fields(smat_pkg::ACT_QUERY, SHADOW_DEPTH, 5'd0, 5'd0, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, 32'hFFFF_FFFF, 5'd31, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_count_cases();
    send_fields(smat_pkg::ACT_WRITE, 32'd100, 5'd31, 5'd5, 32'hA5A5_A5A5);
    send_fields(smat_pkg::ACT_QUERY, 32'd115, 5'd0, 5'd5, 32'd0);
    send_fields(smat_pkg::ACT_QUERY, 32'd116, 5'd0, 5'd5, 32'd0);
    send_fields(smat_pkg::ACT_WRITE, 32'hFFFF_FFFF, 5'd0, 5'd9, 32'd9);
    send_fields(smat_pkg::ACT_READ, 32'hFFFF_FFFF, 5'd0, 5'd9, 32'd0);
  endtask

  task automatic test_unused_action();
    send_fields(ACT_UNUSED, 32'd100, 5'd16, 5'd5, 32'hFFFF_FFFF);
    send_fields(smat_pkg::ACT_QUERY, 32'd100, 5'd0, 5'd5, 32'd0);
  endtask

  task automatic test_random();
    smat_pkg::req_t item;
    int unsigned sel;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      gaps_on = !(k >= 700 && k < 1100);
      sel = $urandom_range(0, 99);
      if (sel < 30) item.action = smat_pkg::ACT_WRITE;
      else if (sel < 60) item.action = smat_pkg::ACT_READ;
      else if (sel < 95) item.action = smat_pkg::ACT_QUERY;
      else item.action = ACT_UNUSED;
      sel = $urandom_range(0, 99);
      if (sel < 40) item.address = $urandom_range(0, 255);
      else if (sel < 70) item.address = $urandom_range(SHADOW_DEPTH - 256, SHADOW_DEPTH - 1);
      else if (sel < 85) item.address = $urandom_range(0, SHADOW_DEPTH - 1);
      else item.address = $urandom();
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        item.byte_count = smat_pkg::COUNT_W'($urandom_range(1, smat_pkg::MAX_ACCESS_BYTES_DEF));
      end else if (sel < 88) begin
        item.byte_count = 5'd0;
      end else begin
        item.byte_count =
          smat_pkg::COUNT_W'($urandom_range(smat_pkg::MAX_ACCESS_BYTES_DEF + 1, 31));
      end
      item.thread_id = ($urandom_range(0, 1) != 0) ? smat_pkg::TID_W'($urandom_range(0, 3))
                                                   : smat_pkg::TID_W'($urandom_range(0, 31));
      item.event_id = $urandom();
      send_request(item);
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < SHADOW_DEPTH; i++) begin
      writer_shadow[i] = '0;
      event_shadow[i]  = '0;
      reader_shadow[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_write_read_query();
    test_range_edges();
    test_count_cases();
    test_unused_action();
    test_random();
    start <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d writes, %0d reads, %0d queries; %0d range errors, %0d read hits",
             write_count, read_count, query_count, error_count, hit_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
